### rtl/core/klb_pkg.sv
// shared constants, types and helpers of the keyboard line buffer
package klb_pkg;

	// line store geometry
	localparam int LINE_CAPACITY = 256;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int CMP_W         = (ADDR_W > 8) ? ADDR_W : 8;

	// special keys
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_NEWLINE   = 8'd10;

	// request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	// one result word
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [2:0] bytes_valid;
		logic       last;
		logic       ready_flag;
		logic [7:0] held_length;
		logic [7:0] copied_count;
	} result_t;

	// low eight bits of a length or count
	function automatic logic [7:0] to_byte(input addr_t v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		return w[7:0];
	endfunction

endpackage

### rtl/core/klb_cmd_if.sv
// request channel: push or read word with valid/ready
interface klb_cmd_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_in;
	logic [7:0] read_len;

	modport source (output valid, output req_type, output char_in, output read_len,
		input ready);
	modport sink (input valid, input req_type, input char_in, input read_len,
		output ready);
endinterface

### rtl/core/klb_rsp_if.sv
// result channel: status or line data word with valid/ready
interface klb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic [7:0] byte3;
	logic [2:0] bytes_valid;
	logic       last;
	logic       ready_flag;
	logic [7:0] held_length;
	logic [7:0] copied_count;

	modport source (output valid, output byte0, output byte1, output byte2, output byte3,
		output bytes_valid, output last, output ready_flag, output held_length,
		output copied_count, input ready);
	modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
		input bytes_valid, input last, input ready_flag, input held_length,
		input copied_count, output ready);
endinterface

### rtl/core/klb_line_ram.sv
// line store: one write port, one read port with registered read data
module klb_line_ram (
	input  logic           clk,
	input  logic           we,
	input  klb_pkg::addr_t waddr,
	input  logic [7:0]     wdata,
	input  klb_pkg::addr_t raddr,
	output logic [7:0]     rdata
);
	import klb_pkg::*;

	logic [7:0] mem [LINE_CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, read data registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/klb_out_reg.sv
// output register: holds one result word until the sink takes it
module klb_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  klb_pkg::result_t res,
	output logic             free,
	klb_rsp_if.source        rsp
);
	import klb_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || rsp.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.byte0        = res_q.byte0;
	assign rsp.byte1        = res_q.byte1;
	assign rsp.byte2        = res_q.byte2;
	assign rsp.byte3        = res_q.byte3;
	assign rsp.bytes_valid  = res_q.bytes_valid;
	assign rsp.last         = res_q.last;
	assign rsp.ready_flag   = res_q.ready_flag;
	assign rsp.held_length  = res_q.held_length;
	assign rsp.copied_count = res_q.copied_count;
endmodule

### rtl/core/keyboard_line_edit_buffer_core.sv
// Cooked-mode keyboard line buffer. Each request word is a character push or a read of the
// completed line. A push (backspace removes the last byte, other bytes append while room is
// left, newline marks the line ready) is accepted, then its status word is loaded into the
// output register, and it answers with one status word. A read of a ready line first fetches
// the last copied byte to strip a trailing newline, then streams the line from a byte memory
// with one registered read port four bytes to a word, each word gathered byte by byte through
// that read port and then loaded into the output register; the load waits while that register
// is full and not being taken. A read of a line not ready, or of no bytes, answers with one
// status word. One request is handled at a time; the output register lets a finished word
// wait while the next request is taken in.
module keyboard_line_edit_buffer_core (
	input  logic    clk,
	input  logic    arst_n,
	klb_cmd_if.sink   cmd,
	klb_rsp_if.source rsp
);
	import klb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_STAT   = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_GATHER = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t     state_q;
	addr_t      len_q;
	logic       rdy_q;
	addr_t      copy_q;
	addr_t      base_q;
	logic [2:0] issue_q;
	logic [2:0] got_q;
	logic       pend_q;
	logic [7:0] lane_q [4];

	logic       accept;
	logic       we;
	addr_t      raddr;
	logic [7:0] rdata;
	addr_t      copy_c;
	addr_t      copy_dec;
	addr_t      rem_c;
	logic [CMP_W-1:0] remx;
	logic [2:0] n_c;
	logic       last_c;
	logic       free;
	logic       load;
	result_t    res_c;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// bytes to copy on a read
	always_comb begin
		logic [CMP_W-1:0] want;
		logic [CMP_W-1:0] have;
		want   = CMP_W'(cmd.read_len);
		have   = CMP_W'(len_q);
		copy_c = (want < have) ? want[ADDR_W-1:0] : len_q;
	end

	assign copy_dec = copy_q - addr_t'(1);

	// size of the current chunk
	assign rem_c  = copy_q - base_q;
	assign remx   = CMP_W'(rem_c);
	assign n_c    = (remx >= CMP_W'(4)) ? 3'd4 : remx[2:0];
	assign last_c = (remx <= CMP_W'(4));

	// line store write on an accepted append
	assign we = accept && (cmd.req_type == REQ_PUSH) && (cmd.char_in != KEY_BACKSPACE)
		&& (len_q < addr_t'(LINE_CAPACITY - 1));

	// read address: last copied byte at read start, then the streamed bytes
	always_comb begin
		if (state_q == ST_IDLE) begin
			raddr = copy_c - addr_t'(1);
		end else begin
			raddr = base_q + addr_t'(issue_q);
		end
	end

	klb_line_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (len_q),
		.wdata (cmd.char_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result word assembly
	always_comb begin
		res_c.byte0        = lane_q[0];
		res_c.byte1        = lane_q[1];
		res_c.byte2        = lane_q[2];
		res_c.byte3        = lane_q[3];
		res_c.bytes_valid  = n_c;
		res_c.last         = last_c;
		res_c.ready_flag   = rdy_q;
		res_c.held_length  = to_byte(len_q);
		res_c.copied_count = to_byte(copy_q);
		load               = 1'b0;
		unique case (state_q)
			ST_STAT: begin
				res_c.byte0        = '0;
				res_c.byte1        = '0;
				res_c.byte2        = '0;
				res_c.byte3        = '0;
				res_c.bytes_valid  = '0;
				res_c.last         = 1'b1;
				res_c.copied_count = '0;
				load               = free;
			end
			ST_EMIT: begin
				load = free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	klb_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (res_c),
		.free   (free),
		.rsp    (rsp)
	);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			rdy_q   <= 1'b0;
			copy_q  <= '0;
			base_q  <= '0;
			issue_q <= '0;
			got_q   <= '0;
			pend_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				lane_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.req_type == REQ_PUSH) begin
							if (cmd.char_in == KEY_BACKSPACE) begin
								if (len_q != '0) begin
									len_q <= len_q - addr_t'(1);
								end
							end else begin
								if (we) begin
									len_q <= len_q + addr_t'(1);
								end
								if (cmd.char_in == KEY_NEWLINE) begin
									rdy_q <= 1'b1;
								end
							end
							state_q <= ST_STAT;
						end else if (!rdy_q) begin
							state_q <= ST_STAT;
						end else if (copy_c == '0) begin
							len_q   <= '0;
							rdy_q   <= 1'b0;
							state_q <= ST_STAT;
						end else begin
							copy_q  <= copy_c;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// strip a trailing newline, clear the line
					len_q   <= '0;
					rdy_q   <= 1'b0;
					base_q  <= '0;
					issue_q <= '0;
					got_q   <= '0;
					pend_q  <= 1'b0;
					for (int i = 0; i < 4; i++) begin
						lane_q[i] <= '0;
					end
					if (rdata == KEY_NEWLINE) begin
						copy_q <= copy_dec;
						if (copy_dec == '0) begin
							state_q <= ST_STAT;
						end else begin
							state_q <= ST_GATHER;
						end
					end else begin
						state_q <= ST_GATHER;
					end
				end
				ST_GATHER: begin
					// issue reads and catch each byte in the cycle after its read
					pend_q <= (issue_q < n_c);
					if (issue_q < n_c) begin
						issue_q <= issue_q + 3'd1;
					end
					if (pend_q) begin
						lane_q[got_q[1:0]] <= rdata;
						got_q              <= got_q + 3'd1;
					end
					if (got_q == n_c) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (free) begin
						if (last_c) begin
							state_q <= ST_IDLE;
						end else begin
							base_q  <= base_q + addr_t'(n_c);
							issue_q <= '0;
							got_q   <= '0;
							pend_q  <= 1'b0;
							for (int i = 0; i < 4; i++) begin
								lane_q[i] <= '0;
							end
							state_q <= ST_GATHER;
						end
					end
				end
				ST_STAT: begin
					if (free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

### tb/sv/keyboard_line_edit_buffer_core_tb.sv
// self-checking testbench for the keyboard line edit buffer core
module keyboard_line_edit_buffer_core_tb;
	import klb_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;

	logic clk = 1'b0;
	logic arst_n;

	klb_cmd_if cmd_bus ();
	klb_rsp_if rsp_bus ();

	keyboard_line_edit_buffer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// line state mirror
	logic [7:0]  line_mem [LINE_CAPACITY];
	int unsigned mirror_len = 0;
	bit          line_rdy   = 1'b0;

	// result words still owed by the block, oldest first
	result_t due_words [$];

	int  errors      = 0;
	int  cycle_count = 0;
	int  hold_cycles = 0;
	int  sink_stall  = 0;
	bit  idle_on     = 1'b1;

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
	end

	// one line per mismatch, and count it
	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	// status word for a push, a read of a line not ready or an empty read
	function automatic result_t status_word();
		result_t w;
		w              = '0;
		w.last         = 1'b1;
		w.ready_flag   = line_rdy;
		w.held_length  = 8'(mirror_len);
		w.copied_count = 8'd0;
		return w;
	endfunction

	// apply one request to the line mirror and queue the words it yields
	task automatic model_line_edit(input logic req, input logic [7:0] ch,
		input logic [7:0] want);
		result_t     w;
		int unsigned copy;
		int unsigned n;
		logic [7:0]  four [4];

		if (req == REQ_PUSH) begin
			if (ch == KEY_BACKSPACE) begin
				if (mirror_len > 0)
					mirror_len--;
			end else begin
				if (mirror_len < LINE_CAPACITY - 1) begin
					line_mem[mirror_len] = ch;
					mirror_len++;
				end
				if (ch == KEY_NEWLINE)
					line_rdy = 1'b1;
			end
			due_words.push_back(status_word());
		end else if (!line_rdy) begin
			due_words.push_back(status_word());
		end else begin
			copy = (want < mirror_len) ? want : mirror_len;
			// trailing newline of the copied part is dropped
			if (copy > 0 && line_mem[copy-1] == KEY_NEWLINE)
				copy--;
			mirror_len = 0;
			line_rdy   = 1'b0;
			if (copy == 0) begin
				due_words.push_back(status_word());
			end else begin
				for (int unsigned i = 0; i < copy; i += 4) begin
					n = (copy - i > 4) ? 4 : copy - i;
					for (int unsigned j = 0; j < 4; j++)
						four[j] = (j < n) ? line_mem[i+j] : 8'd0;
					w              = '0;
					w.byte0        = four[0];
					w.byte1        = four[1];
					w.byte2        = four[2];
					w.byte3        = four[3];
					w.bytes_valid  = 3'(n);
					w.last         = (i + 4 >= copy);
					w.ready_flag   = line_rdy;
					w.held_length  = 8'(mirror_len);
					w.copied_count = 8'(copy);
					due_words.push_back(w);
				end
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
		input logic [7:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
	endtask

	// compare the accepted word with the oldest expectation
	task automatic check_word();
		result_t exp;
		if (due_words.size() == 0) begin
			report_mismatch("result word with nothing expected");
			return;
		end
		exp = due_words.pop_front();
		compare_field("byte0", rsp_bus.byte0, exp.byte0);
		compare_field("byte1", rsp_bus.byte1, exp.byte1);
		compare_field("byte2", rsp_bus.byte2, exp.byte2);
		compare_field("byte3", rsp_bus.byte3, exp.byte3);
		compare_field("bytes_valid", 8'(rsp_bus.bytes_valid), 8'(exp.bytes_valid));
		compare_field("last", 8'(rsp_bus.last), 8'(exp.last));
		compare_field("ready_flag", 8'(rsp_bus.ready_flag), 8'(exp.ready_flag));
		compare_field("held_length", rsp_bus.held_length, exp.held_length);
		compare_field("copied_count", rsp_bus.copied_count, exp.copied_count);
	endtask

	// receiver: check accepted words, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			check_word();
		if (hold_cycles != 0) begin
			rsp_bus.ready <= 1'b0;
		end else if (sink_stall != 0) begin
			rsp_bus.ready <= 1'b0;
			sink_stall    <= sink_stall - 1;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			rsp_bus.ready <= 1'b0;
			sink_stall    <= $urandom_range(0, 12);
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// offer one request word and wait until it is taken
	task automatic send_word(input logic req, input logic [7:0] ch,
		input logic [7:0] want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		cmd_bus.valid    <= 1'b1;
		cmd_bus.req_type <= req;
		cmd_bus.char_in  <= ch;
		cmd_bus.read_len <= want;
		@(posedge clk);
		while (cmd_bus.ready !== 1'b1)
			@(posedge clk);
		model_line_edit(req, ch, want);
	endtask

	task automatic push_char(input logic [7:0] ch);
		send_word(REQ_PUSH, ch, 8'($urandom_range(0, 255)));
	endtask

	task automatic read_line(input logic [7:0] want);
		send_word(REQ_READ, 8'($urandom_range(0, 255)), want);
	endtask

	// lower valid and let a cycle pass so the next raise is in a new step
	task automatic stop_sending();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (due_words.size() != 0)
			@(posedge clk);
	endtask

	// any byte except backspace and newline
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == KEY_BACKSPACE || c == KEY_NEWLINE);
		return c;
	endfunction

	// field extremes and the edit and read corner cases
	task automatic test_directed();
		read_line(8'd255);          // read while not ready
		read_line(8'd0);
		push_char(KEY_BACKSPACE);   // backspace on empty line
		push_char(8'h00);
		push_char(8'hff);
		push_char(8'h41);
		push_char(KEY_BACKSPACE);
		push_char(KEY_NEWLINE);
		push_char(KEY_BACKSPACE);   // backspace while ready drops the newline
		read_line(8'd255);
		push_char(KEY_NEWLINE);     // line of only a newline reads as nothing
		read_line(8'd255);
		push_char(8'h42);
		push_char(KEY_NEWLINE);
		read_line(8'd0);            // zero-length read still clears the line
		for (int i = 0; i < 5; i++)
			push_char(8'h61 + 8'(i));
		push_char(KEY_NEWLINE);
		read_line(8'd3);            // short read keeps no newline, drops the rest
		read_line(8'd255);
	endtask

	// fill the line to its limit of LINE_CAPACITY - 1 bytes, then read it all back
	task automatic test_line_full();
		for (int i = 0; i < LINE_CAPACITY - 1; i++)
			push_char(plain_char());
		push_char(8'h7e);           // dropped
		push_char(KEY_NEWLINE);     // dropped but still marks the line ready
		read_line(8'd255);
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_backpressure();
		hold_cycles <= 300;
		for (int i = 0; i < 10; i++)
			push_char(plain_char());
		push_char(KEY_NEWLINE);
		read_line(8'd255);
		stop_sending();
		wait_drained();
	endtask

	// mostly whole lines with random content, some noise and broken lines
	task automatic test_random_lines(input int count);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				if ($urandom_range(0, 1))
					push_char(8'($urandom_range(0, 255)));
				else
					read_line(8'($urandom_range(0, 255)));
				sent++;
			end else if (pick == 1) begin
				// unfinished line, carried into what follows
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					push_char(8'($urandom_range(0, 255)));
				sent += len;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
				                                  : $urandom_range(0, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						push_char(KEY_BACKSPACE);
					else
						push_char(8'($urandom_range(0, 255)));
				end
				push_char(KEY_NEWLINE);
				case ($urandom_range(0, 3))
					0:       read_line(8'd255);
					1:       read_line(8'd0);
					2:       read_line(8'($urandom_range(0, len + 1)));
					default: read_line(8'($urandom_range(0, 255)));
				endcase
				sent += len + 2;
			end
		end
	endtask

	// closing stretch without any idling
	task automatic test_quiet_tail();
		idle_on = 1'b0;
		test_random_lines(15);
	endtask

	// sequence of tests
	initial begin
		arst_n           = 1'b0;
		cmd_bus.valid    = 1'b0;
		cmd_bus.req_type = REQ_PUSH;
		cmd_bus.char_in  = 8'd0;
		cmd_bus.read_len = 8'd0;
		rsp_bus.ready    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_line_full();
		test_backpressure();
		test_random_lines(30);
		test_quiet_tail();

		stop_sending();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
rtl/core/klb_pkg.sv
rtl/core/klb_cmd_if.sv
rtl/core/klb_rsp_if.sv
rtl/core/klb_line_ram.sv
rtl/core/klb_out_reg.sv
rtl/core/keyboard_line_edit_buffer_core.sv
tb/sv/keyboard_line_edit_buffer_core_tb.sv
